[design/rpn_pkg.sv]
// shared constants, types and operation codes of the stack calculator
`default_nettype none

package rpn_pkg;

	localparam int STACK_DEPTH = 10;
	localparam int VALUE_WIDTH = 32;

	localparam int REQ_W       = 4;
	localparam int PUSH_W      = 18;
	localparam int OUT_W       = 32;
	localparam int COUNT_OUT_W = 4;
	localparam int LIMIT_W     = 31;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd99999;

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef enum logic [REQ_W-1:0] {
		OP_CLEAR = 4'd0,
		OP_PUSH  = 4'd1,
		OP_POP   = 4'd2,
		OP_DUP   = 4'd3,
		OP_ADD   = 4'd4,
		OP_SUB   = 4'd5,
		OP_MUL   = 4'd6,
		OP_DIV   = 4'd7,
		OP_NEG   = 4'd8,
		OP_SWAP  = 4'd9
	} req_op_t;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_SUB = 3'd1,
		ALU_NEG = 3'd2,
		ALU_MUL = 3'd3,
		ALU_DIV = 3'd4
	} alu_op_t;

	typedef struct packed {
		logic    go;
		alu_op_t op;
	} alu_req_t;

endpackage

`default_nettype wire

[design/rpn_alu.sv]
// shared arithmetic unit: one adder for add, sub, negate, shift-add multiply and restoring divide
`default_nettype none

module rpn_alu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rpn_pkg::alu_req_t req,
	input  wire rpn_pkg::value_t  opa,
	input  wire rpn_pkg::value_t  opb,
	output logic                  done,
	output rpn_pkg::value_t       result
);
	import rpn_pkg::*;

	localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_MUL  = 4'b0010,
		A_DIV  = 4'b0100,
		A_FIX  = 4'b1000
	} alu_state_t;

	alu_state_t              st_q;
	logic [STEP_W-1:0]       step_q;
	logic [VALUE_WIDTH-1:0]  acc_q;
	logic [VALUE_WIDTH-1:0]  mcand_q;
	logic [VALUE_WIDTH-1:0]  mq_q;
	logic [VALUE_WIDTH-1:0]  rem_q;
	logic                    neg_q;
	logic                    done_q;
	value_t                  result_q;

	logic [VALUE_WIDTH:0]    add_x, add_y, add_sum;
	logic                    add_cin;
	logic [VALUE_WIDTH:0]    shifted;
	logic [VALUE_WIDTH-1:0]  mag_a, mag_b, quo_next;

	assign shifted  = {rem_q, mq_q[VALUE_WIDTH-1]};
	assign mag_a    = opa[VALUE_WIDTH-1] ? -opa : opa;
	assign mag_b    = opb[VALUE_WIDTH-1] ? -opb : opb;
	assign quo_next = {mq_q[VALUE_WIDTH-2:0], ~add_sum[VALUE_WIDTH]};

	// operand selection for the single shared adder
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_cin = 1'b0;
		case (st_q)
			A_IDLE: begin
				case (req.op)
					ALU_ADD: begin
						add_x = {1'b0, opa};
						add_y = {1'b0, opb};
					end
					ALU_SUB: begin
						add_x   = {1'b0, opa};
						add_y   = {1'b0, ~opb};
						add_cin = 1'b1;
					end
					ALU_NEG: begin
						add_y   = {1'b0, ~opb};
						add_cin = 1'b1;
					end
					default: begin
						add_x = '0;
					end
				endcase
			end
			A_MUL: begin
				add_x = {1'b0, acc_q};
				add_y = mq_q[0] ? {1'b0, mcand_q} : '0;
			end
			A_DIV: begin
				// trial subtract, borrow shows in the top bit
				add_x   = shifted;
				add_y   = ~{1'b0, mcand_q};
				add_cin = 1'b1;
			end
			A_FIX: begin
				add_y   = {1'b0, ~mq_q};
				add_cin = 1'b1;
			end
			default: begin
				add_x = '0;
			end
		endcase
		add_sum = add_x + add_y + (VALUE_WIDTH + 1)'(add_cin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				A_IDLE: begin
					if (req.go) begin
						case (req.op)
							ALU_MUL: begin
								acc_q   <= '0;
								mcand_q <= opa;
								mq_q    <= opb;
								step_q  <= STEP_W'(VALUE_WIDTH);
								st_q    <= A_MUL;
							end
							ALU_DIV: begin
								mcand_q <= mag_b;
								mq_q    <= mag_a;
								rem_q   <= '0;
								neg_q   <= opa[VALUE_WIDTH-1] ^ opb[VALUE_WIDTH-1];
								step_q  <= STEP_W'(VALUE_WIDTH);
								st_q    <= A_DIV;
							end
							default: begin
								result_q <= add_sum[VALUE_WIDTH-1:0];
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				A_MUL: begin
					acc_q   <= add_sum[VALUE_WIDTH-1:0];
					mcand_q <= mcand_q << 1;
					mq_q    <= mq_q >> 1;
					step_q  <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						result_q <= add_sum[VALUE_WIDTH-1:0];
						done_q   <= 1'b1;
						st_q     <= A_IDLE;
					end
				end
				A_DIV: begin
					rem_q  <= add_sum[VALUE_WIDTH] ? shifted[VALUE_WIDTH-1:0]
						: add_sum[VALUE_WIDTH-1:0];
					mq_q   <= quo_next;
					step_q <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						if (neg_q) begin
							st_q <= A_FIX;
						end else begin
							result_q <= quo_next;
							done_q   <= 1'b1;
							st_q     <= A_IDLE;
						end
					end
				end
				A_FIX: begin
					// sign fix of the quotient
					result_q <= add_sum[VALUE_WIDTH-1:0];
					done_q   <= 1'b1;
					st_q     <= A_IDLE;
				end
				default: begin
					st_q <= A_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

[design/rpn_stack_calculator_core.sv]
// top level of the reverse-polish stack calculator: sequencer, stack memory and result register
//
// channel  signals                                   handshake
// request  start, req_type, push_value               taken when start and !busy
// result   done, top_value, entry_count,             done high for one cycle, no backpressure
//          stack_empty, error
// config   cfg_valid, cfg_data, cfg_ready            written when cfg_valid and cfg_ready
//
// a request passes through the read, execute and done states to the done strobe, with a swap
// state added for swap and a wait state for add, sub, negate, mul and div; mul and div stay in
// the wait state while the shared adder does one multiply or divide bit per cycle
// busy stays high from acceptance until the cycle that shows done
// reset empties the stack and loads the display limit with 99999; stack entries are not cleared
// results are never stalled; cfg_ready is always high
`default_nettype none

module rpn_stack_calculator_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [rpn_pkg::REQ_W-1:0]          req_type,
	input  wire logic signed [rpn_pkg::PUSH_W-1:0]  push_value,
	output logic                                    done,
	output logic signed [rpn_pkg::OUT_W-1:0]        top_value,
	output logic [rpn_pkg::COUNT_OUT_W-1:0]         entry_count,
	output logic                                    stack_empty,
	output logic                                    error,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rpn_pkg::LIMIT_W-1:0]        cfg_data
);
	import rpn_pkg::*;

	localparam int CMP_W = (VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_EXEC = 6'b000100,
		S_WAIT = 6'b001000,
		S_SWAP = 6'b010000,
		S_DONE = 6'b100000
	} seq_state_t;

	seq_state_t state_q, state_d;

	logic [LIMIT_W-1:0]  limit_q;
	req_op_t             op_q;
	value_t              pv_q;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	value_t              top_q, top_d;
	logic                fail_q, fail_d;

	value_t              stack_q [STACK_DEPTH];
	value_t              rd_a_q, rd_b_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	value_t              mem_wdata;

	logic [CNT_W-1:0]    cnt_m1, cnt_m2;
	logic                has_one, has_two, has_room;

	alu_req_t            alu_req;
	logic                alu_done;
	value_t              alu_result;

	logic [VALUE_WIDTH-1:0] top_mag;
	logic                   over_limit;

	logic                        done_q;
	logic signed [OUT_W-1:0]     top_value_q;
	logic [COUNT_OUT_W-1:0]      entry_count_q;
	logic                        empty_q;
	logic                        error_q;

	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign cnt_m2   = cnt_q - CNT_W'(2);
	assign has_one  = cnt_q != '0;
	assign has_two  = cnt_q > CNT_W'(1);
	assign has_room = cnt_q < DEPTH_C;

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (rd_a_q),
		.opb    (rd_b_q),
		.done   (alu_done),
		.result (alu_result)
	);

	// sequencer decisions
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		top_d     = top_q;
		fail_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[ADDR_W-1:0];
		mem_wdata = pv_q;
		alu_req   = '{go: 1'b0, op: ALU_ADD};
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (op_q)
					OP_CLEAR: begin
						cnt_d = '0;
						top_d = '0;
					end
					OP_PUSH: begin
						if (!has_room) begin
							fail_d = 1'b1;
						end else begin
							mem_we = 1'b1;
							cnt_d  = cnt_q + CNT_W'(1);
							top_d  = pv_q;
						end
					end
					OP_POP: begin
						if (!has_one) begin
							fail_d = 1'b1;
						end else begin
							cnt_d = cnt_m1;
							top_d = has_two ? rd_a_q : '0;
						end
					end
					OP_DUP: begin
						if (!has_one || !has_room) begin
							fail_d = 1'b1;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = rd_b_q;
							cnt_d     = cnt_q + CNT_W'(1);
							top_d     = rd_b_q;
						end
					end
					OP_ADD, OP_SUB, OP_MUL: begin
						if (!has_two) begin
							fail_d = 1'b1;
						end else begin
							alu_req.go = 1'b1;
							alu_req.op = (op_q == OP_ADD) ? ALU_ADD
								: (op_q == OP_SUB) ? ALU_SUB : ALU_MUL;
							state_d    = S_WAIT;
						end
					end
					OP_DIV: begin
						if (!has_two || rd_b_q == '0) begin
							fail_d = 1'b1;
						end else begin
							alu_req = '{go: 1'b1, op: ALU_DIV};
							state_d = S_WAIT;
						end
					end
					OP_NEG: begin
						if (!has_one) begin
							fail_d = 1'b1;
						end else begin
							alu_req = '{go: 1'b1, op: ALU_NEG};
							state_d = S_WAIT;
						end
					end
					OP_SWAP: begin
						if (!has_two) begin
							fail_d = 1'b1;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = cnt_m1[ADDR_W-1:0];
							mem_wdata = rd_a_q;
							top_d     = rd_a_q;
							state_d   = S_SWAP;
						end
					end
					default: begin
						fail_d = 1'b1;
					end
				endcase
				// failed request leaves the stack alone and shows the old top
				if (fail_d) begin
					cnt_d   = cnt_q;
					top_d   = has_one ? rd_b_q : '0;
					state_d = S_DONE;
				end
			end
			S_WAIT: begin
				if (alu_done) begin
					mem_we    = 1'b1;
					mem_waddr = (op_q == OP_NEG) ? cnt_m1[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
					mem_wdata = alu_result;
					top_d     = alu_result;
					cnt_d     = (op_q == OP_NEG) ? cnt_q : cnt_m1;
					state_d   = S_DONE;
				end
			end
			S_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_m2[ADDR_W-1:0];
				mem_wdata = rd_b_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// stack memory, read ports registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_q[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_READ) begin
			rd_a_q <= stack_q[cnt_m2[ADDR_W-1:0]];
			rd_b_q <= stack_q[cnt_m1[ADDR_W-1:0]];
		end
	end

	assign top_mag    = top_q[VALUE_WIDTH-1] ? -top_q : top_q;
	assign over_limit = CMP_W'(top_mag) > CMP_W'(limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			limit_q <= LIMIT_RESET;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= state_q == S_DONE;
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (state_q == S_IDLE && start) begin
			op_q <= req_op_t'(req_type);
			pv_q <= VALUE_WIDTH'(push_value);
		end
		if (state_q == S_EXEC) begin
			fail_q <= fail_d;
		end
		if (state_q == S_DONE) begin
			top_value_q   <= OUT_W'(top_q);
			entry_count_q <= COUNT_OUT_W'(cnt_q);
			empty_q       <= cnt_q == '0;
			error_q       <= fail_q || (cnt_q != '0 && over_limit);
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign top_value   = top_value_q;
	assign entry_count = entry_count_q;
	assign stack_empty = empty_q;
	assign error       = error_q;
	assign cfg_ready   = 1'b1;

	// fill count never passes the stack depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("fill count above stack depth");

	// stack writes stay inside the memory
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr < ADDR_W'(STACK_DEPTH)))
		else $error("stack write outside memory");

	// an accepted request holds busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// busy drops only as the result is shown
	a_done_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy released without a result");

endmodule

`default_nettype wire
